[sv/accel_tilt_with_norm_gate_macros.svh]
// Assertion macros shared by the tilt block.
`ifndef ACCEL_TILT_WITH_NORM_GATE_MACROS_SVH
`define ACCEL_TILT_WITH_NORM_GATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ATN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ATN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/atn_pkg.sv]
package atn_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CFG_BITS     = 16;
    localparam int ACC_BITS     = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int SCALE_SHIFT  = 30;
    // radicand holds x^2+y^2+z^2, root is half as wide
    localparam int RAD_BITS     = 2 * SAMPLE_BITS + 2;
    localparam int ROOT_BITS    = RAD_BITS / 2;
    // scaled operand plus CORDIC growth and sign
    localparam int CORD_BITS    = SAMPLE_BITS + SCALE_SHIFT + 4;

    localparam logic [CFG_BITS-1:0] GRAVITY_RST = 16'd16384;
    localparam logic [CFG_BITS-1:0] TOL_RST     = 16'd3342;

    // register indexes
    localparam logic REG_GRAVITY = 1'b0;
    localparam logic REG_TOL     = 1'b1;

    localparam logic [ACC_BITS-1:0] QUARTER_TURN = 32'h4000_0000;

    // arctan(2^-i), 2^32 counts per turn
    localparam logic [ACC_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
    } t_accel_in;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] roll_angle;
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic                         trusted;
    } t_tilt_out;

    // one square-root lane: remaining radicand bits, partial remainder, root
    typedef struct packed {
        logic [RAD_BITS-1:0]    rad;
        logic [ROOT_BITS+1:0]   rem;
        logic [ROOT_BITS-1:0]   root;
    } t_sqrt_lane;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CORD_BITS-1:0] xv;
        logic signed [CORD_BITS-1:0] yv;
        logic [ACC_BITS-1:0]         acc;
        logic                        zero;
    } t_cord_lane;

endpackage

[sv/accel_tilt_with_norm_gate.sv]
// Pipeline from input transaction to result: square, sum, 17 root digit cells,
//   gate, 32 CORDIC cells, output register.
// Throughput: one transaction per cycle; the whole pipeline stalls only while a
//   result in the output register is not taken.
// Reset (synchronous, active low): pipeline empty, gravity 16384, tolerance 3342.
`include "accel_tilt_with_norm_gate_macros.svh"

module accel_tilt_with_norm_gate (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  atn_pkg::t_accel_in      i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output atn_pkg::t_tilt_out      o_out_data,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_idx,
    input  logic [atn_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    localparam int SB   = atn_pkg::SAMPLE_BITS;
    localparam int RB   = atn_pkg::ROOT_BITS;
    localparam int CB   = atn_pkg::CORD_BITS;
    localparam int AB   = atn_pkg::ANGLE_BITS;
    localparam int NS   = atn_pkg::CORDIC_STEPS;
    localparam int DEVW = atn_pkg::ROOT_BITS + atn_pkg::CFG_BITS;
    localparam logic [atn_pkg::ACC_BITS-1:0] ROUND_HALF =
        atn_pkg::ACC_BITS'(1) << (atn_pkg::ACC_BITS - 1 - AB);
    localparam logic signed [AB-1:0] PITCH_MAX = AB'(1) << (AB - 2);

    logic w_adv;
    logic r_out_vld;

    // configuration registers
    logic [atn_pkg::CFG_BITS-1:0] r_gravity, r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= atn_pkg::GRAVITY_RST;
            r_tol     <= atn_pkg::TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                atn_pkg::REG_GRAVITY: r_gravity <= i_cfg_wdata;
                atn_pkg::REG_TOL:     r_tol     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output register can take a result
    assign w_adv      = !r_out_vld || i_out_ready;
    assign o_in_ready = w_adv;

    // stage 0: squares
    logic                   r_s0_vld;
    logic [2*SB-1:0]        r_sq_x, r_sq_y, r_sq_z;
    atn_pkg::t_accel_in     r_s0_side;
    logic signed [2*SB-1:0] w_px, w_py, w_pz;

    assign w_px = i_in_data.accel_x * i_in_data.accel_x;
    assign w_py = i_in_data.accel_y * i_in_data.accel_y;
    assign w_pz = i_in_data.accel_z * i_in_data.accel_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_x    <= w_px;
            r_sq_y    <= w_py;
            r_sq_z    <= w_pz;
            r_s0_side <= i_in_data;
        end
    end

    // stage 1: sums, loaded into the root chain
    logic                       r_s1_vld;
    atn_pkg::t_sqrt_lane [1:0]  r_s1_lane;
    atn_pkg::t_accel_in         r_s1_side;
    logic [atn_pkg::RAD_BITS-1:0] w_yz, w_all;

    assign w_yz  = atn_pkg::RAD_BITS'(r_sq_y) + atn_pkg::RAD_BITS'(r_sq_z);
    assign w_all = w_yz + atn_pkg::RAD_BITS'(r_sq_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_lane[0] <= '{rad: w_all, rem: '0, root: '0};
            r_s1_lane[1] <= '{rad: w_yz,  rem: '0, root: '0};
            r_s1_side    <= r_s0_side;
        end
    end

    // root digit cells
    logic                       w_sq_vld  [RB+1];
    atn_pkg::t_sqrt_lane [1:0]  w_sq_lane [RB+1];
    atn_pkg::t_accel_in         w_sq_side [RB+1];

    assign w_sq_vld[0]  = r_s1_vld;
    assign w_sq_lane[0] = r_s1_lane;
    assign w_sq_side[0] = r_s1_side;

    for (genvar g = 0; g < RB; g++) begin : g_sqrt
        atn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (w_sq_vld[g]),
            .i_lane  (w_sq_lane[g]),
            .i_side  (w_sq_side[g]),
            .o_vld   (w_sq_vld[g+1]),
            .o_lane  (w_sq_lane[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // gate stage: norm check and half-plane pre-rotation
    function automatic atn_pkg::t_cord_lane pre_rot(logic signed [CB-1:0] yy,
                                                    logic signed [CB-1:0] xx);
        atn_pkg::t_cord_lane res;
        res.zero = (yy == '0) && (xx == '0);
        res.xv   = xx;
        res.yv   = yy;
        res.acc  = '0;
        if (xx[CB-1]) begin
            if (!yy[CB-1]) begin
                res.xv  = yy;
                res.yv  = -xx;
                res.acc = atn_pkg::QUARTER_TURN;
            end else begin
                res.xv  = -yy;
                res.yv  = xx;
                res.acc = -atn_pkg::QUARTER_TURN;
            end
        end
        return res;
    endfunction

    logic [RB-1:0]          w_norm, w_syz;
    logic [DEVW-1:0]        w_ne, w_ge, w_dev;
    logic                   w_trust;
    logic signed [CB-1:0]   w_ry, w_rx, w_py_s, w_px_s;
    atn_pkg::t_accel_in     w_gs;

    assign w_norm = w_sq_lane[RB][0].root;
    assign w_syz  = w_sq_lane[RB][1].root;
    assign w_gs   = w_sq_side[RB];
    assign w_ne   = DEVW'(w_norm);
    assign w_ge   = DEVW'(r_gravity);
    assign w_dev  = (w_ne >= w_ge) ? (w_ne - w_ge) : (w_ge - w_ne);
    assign w_trust = (w_norm != '0) && (w_dev <= DEVW'(r_tol));

    // operands scaled by 2^30
    assign w_ry   = CB'(w_gs.accel_y) <<< atn_pkg::SCALE_SHIFT;
    assign w_rx   = CB'(w_gs.accel_z) <<< atn_pkg::SCALE_SHIFT;
    assign w_py_s = (-CB'(w_gs.accel_x)) <<< atn_pkg::SCALE_SHIFT;
    assign w_px_s = signed'(CB'(w_syz)) <<< atn_pkg::SCALE_SHIFT;

    logic                       r_pre_vld;
    atn_pkg::t_cord_lane [1:0]  r_pre_lane;
    logic                       r_pre_trust;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_vld <= 1'b0;
        end else if (w_adv) begin
            r_pre_vld <= w_sq_vld[RB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pre_lane[0] <= pre_rot(w_ry, w_rx);
            r_pre_lane[1] <= pre_rot(w_py_s, w_px_s);
            r_pre_trust   <= w_trust;
        end
    end

    // CORDIC cells
    logic                       w_cd_vld   [NS+1];
    atn_pkg::t_cord_lane [1:0]  w_cd_lane  [NS+1];
    logic                       w_cd_trust [NS+1];

    assign w_cd_vld[0]   = r_pre_vld;
    assign w_cd_lane[0]  = r_pre_lane;
    assign w_cd_trust[0] = r_pre_trust;

    for (genvar g = 0; g < NS; g++) begin : g_cordic
        atn_cordic_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_vld   (w_cd_vld[g]),
            .i_lane  (w_cd_lane[g]),
            .i_trust (w_cd_trust[g]),
            .o_vld   (w_cd_vld[g+1]),
            .o_lane  (w_cd_lane[g+1]),
            .o_trust (w_cd_trust[g+1])
        );
    end

    // output register: round, zero when untrusted or both operands zero
    logic [atn_pkg::ACC_BITS-1:0] w_roll_r, w_pitch_r;
    atn_pkg::t_tilt_out           n_out, r_out;
    logic                         w_tr;

    assign w_roll_r  = w_cd_lane[NS][0].acc + ROUND_HALF;
    assign w_pitch_r = w_cd_lane[NS][1].acc + ROUND_HALF;
    assign w_tr      = w_cd_trust[NS];

    always_comb begin
        n_out.trusted     = w_tr;
        n_out.roll_angle  = '0;
        n_out.pitch_angle = '0;
        if (w_tr && !w_cd_lane[NS][0].zero) begin
            n_out.roll_angle = w_roll_r[atn_pkg::ACC_BITS-1 -: AB];
        end
        if (w_tr && !w_cd_lane[NS][1].zero) begin
            n_out.pitch_angle = w_pitch_r[atn_pkg::ACC_BITS-1 -: AB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_cd_vld[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    `ATN_ASSERT_NOW(a_untrusted_zero, o_out_valid && !o_out_data.trusted, (o_out_data.roll_angle == '0) && (o_out_data.pitch_angle == '0), "untrusted result with nonzero angle")
    `ATN_ASSERT_NOW(a_pitch_range, o_out_valid && o_out_data.trusted, (o_out_data.pitch_angle <= PITCH_MAX) && (o_out_data.pitch_angle >= -PITCH_MAX), "pitch beyond a quarter turn")
    `ATN_ASSERT_NEXT(a_freeze, !w_adv, $stable(r_pre_vld) && $stable(w_cd_vld[NS]), "pipeline moved during a stall")

endmodule

[sv/atn_sqrt_cell.sv]
// One digit of a restoring square root, for the norm lane and the y-z lane.
module atn_sqrt_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  atn_pkg::t_sqrt_lane [1:0]           i_lane,
    input  atn_pkg::t_accel_in                  i_side,
    output logic                                o_vld,
    output atn_pkg::t_sqrt_lane [1:0]           o_lane,
    output atn_pkg::t_accel_in                  o_side
);

    logic                       r_vld;
    atn_pkg::t_sqrt_lane [1:0]  r_lane, n_lane;
    atn_pkg::t_accel_in         r_side;

    function automatic atn_pkg::t_sqrt_lane step(atn_pkg::t_sqrt_lane l);
        logic [atn_pkg::ROOT_BITS+3:0] cur;
        logic [atn_pkg::ROOT_BITS+3:0] trial;
        logic [atn_pkg::ROOT_BITS+3:0] diff;
        atn_pkg::t_sqrt_lane           res;
        cur   = {l.rem, l.rad[atn_pkg::RAD_BITS-1 -: 2]};
        trial = {2'b00, l.root, 2'b01};
        diff  = cur - trial;
        res.rad = {l.rad[atn_pkg::RAD_BITS-3:0], 2'b00};
        if (cur >= trial) begin
            res.rem  = diff[atn_pkg::ROOT_BITS+1:0];
            res.root = {l.root[atn_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
            res.rem  = cur[atn_pkg::ROOT_BITS+1:0];
            res.root = {l.root[atn_pkg::ROOT_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_lane[k] = step(i_lane[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

[sv/atn_cordic_cell.sv]
// One CORDIC vectoring iteration for the roll lane and the pitch lane.
module atn_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  atn_pkg::t_cord_lane [1:0]   i_lane,
    input  logic                        i_trust,
    output logic                        o_vld,
    output atn_pkg::t_cord_lane [1:0]   o_lane,
    output logic                        o_trust
);

    logic                       r_vld;
    atn_pkg::t_cord_lane [1:0]  r_lane, n_lane;
    logic                       r_trust;

    function automatic atn_pkg::t_cord_lane step(atn_pkg::t_cord_lane l);
        logic signed [atn_pkg::CORD_BITS-1:0] dx;
        logic signed [atn_pkg::CORD_BITS-1:0] dy;
        atn_pkg::t_cord_lane                  res;
        dx = l.yv >>> IDX;
        dy = l.xv >>> IDX;
        res.zero = l.zero;
        if (!l.yv[atn_pkg::CORD_BITS-1]) begin
            res.xv  = l.xv + dx;
            res.yv  = l.yv - dy;
            res.acc = l.acc + atn_pkg::ATAN_TAB[IDX];
        end else begin
            res.xv  = l.xv - dx;
            res.yv  = l.yv + dy;
            res.acc = l.acc - atn_pkg::ATAN_TAB[IDX];
        end
        return res;
    endfunction

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_lane[k] = step(i_lane[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane  <= n_lane;
            r_trust <= i_trust;
        end
    end

    assign o_vld   = r_vld;
    assign o_lane  = r_lane;
    assign o_trust = r_trust;

endmodule
